### sv/msfr_pkg.sv
// shared types and constants for the motor status frame receiver
package msfr_pkg;

	localparam int PAYLOAD_DEPTH = 256;

	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = $clog2(PAYLOAD_DEPTH);
	localparam int GRP_W   = 5;
	localparam int LANE_W  = 3;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h55;

	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOMING_MOTOR_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_THRESH  = 2'd2;

	typedef struct packed {
		logic              ram_we;
		logic              ram_re;
		logic [ADDR_W-1:0] addr;
		logic              sum_clr;
		logic              sum_add;
		logic              shift;
		logic              load;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic sum_ok;
	} status_t;

	typedef struct packed {
		logic        [15:0] angle;
		logic signed [15:0] speed;
		logic signed [15:0] current;
		logic        [7:0]  temperature;
		logic        [7:0]  motor_number;
		logic               homing_trigger;
		logic               last;
	} rec_t;

endpackage

### sv/msfr_byte_if.sv
// byte stream channel into the receiver
interface msfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/msfr_rec_if.sv
// decoded motor record channel out of the receiver
interface msfr_rec_if;
	logic               valid;
	logic               ready;
	logic        [15:0] angle;
	logic signed [15:0] speed;
	logic signed [15:0] current;
	logic        [7:0]  temperature;
	logic        [7:0]  motor_number;
	logic               homing_trigger;
	logic               last;

	modport source (output valid, output angle, output speed, output current,
		output temperature, output motor_number, output homing_trigger, output last,
		input ready);
	modport sink (input valid, input angle, input speed, input current,
		input temperature, input motor_number, input homing_trigger, input last,
		output ready);
endinterface

### sv/msfr_ram.sv
// generic single-port ram with registered read
module msfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

### sv/msfr_datapath.sv
// payload buffer, checksum, record assembly and homing detection
module msfr_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msfr_pkg::cmd_t                    cmd,
	output msfr_pkg::status_t                 status,
	input  logic [msfr_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                              cfg_we,
	input  logic [msfr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [msfr_pkg::CFG_W-1:0]        cfg_data,
	output msfr_pkg::rec_t                    rec
);

	logic        homing_en_q;
	logic [7:0]  homing_id_q;
	logic [15:0] thresh_q;
	logic        homed_q;
	logic [7:0]  sum_q;
	logic [63:0] asm_q;
	logic [7:0]  rdata;
	logic [15:0] cur;
	logic [16:0] mag;
	logic        trig;
	msfr_pkg::rec_t rec_q;

	msfr_ram #(.WIDTH(msfr_pkg::BYTE_W), .DEPTH(msfr_pkg::PAYLOAD_DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.re    (cmd.ram_re),
		.addr  (cmd.addr),
		.wdata (rx_byte),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homing_en_q <= 1'b0;
			homing_id_q <= 8'd1;
			thresh_q    <= 16'd32767;
		end else if (cfg_we) begin
			case (cfg_idx)
				msfr_pkg::CFG_HOMING_ENABLE:   homing_en_q <= cfg_data[0];
				msfr_pkg::CFG_HOMING_MOTOR_ID: homing_id_q <= cfg_data[7:0];
				msfr_pkg::CFG_CURRENT_THRESH:  thresh_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + rx_byte;
		end
	end

	assign status.sum_ok = (rx_byte == sum_q);

	// bytes arrive in address order, so shifting in builds the big-endian group
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			asm_q <= {asm_q[55:0], rdata};
		end
	end

	// magnitude kept at 17 bits so -32768 gives 32768
	assign cur  = asm_q[31:16];
	assign mag  = cur[15] ? (17'h10000 - {1'b0, cur}) : {1'b0, cur};
	assign trig = homing_en_q && (asm_q[7:0] == homing_id_q) && !homed_q
		&& (mag >= {1'b0, thresh_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q <= 1'b0;
		end else if (cmd.load && trig) begin
			homed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rec_q.angle          <= asm_q[63:48];
			rec_q.speed          <= asm_q[47:32];
			rec_q.current        <= asm_q[31:16];
			rec_q.temperature    <= asm_q[15:8];
			rec_q.motor_number   <= asm_q[7:0];
			rec_q.homing_trigger <= trig;
			rec_q.last           <= cmd.last;
		end
	end

	assign rec = rec_q;

endmodule

### sv/msfr_ctrl.sv
// frame hunt and record emission sequencer
module msfr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [msfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  msfr_pkg::status_t           status,
	output msfr_pkg::cmd_t              cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_GOT_AA  = 4'd1;
	localparam logic [3:0] ST_LENGTH  = 4'd2;
	localparam logic [3:0] ST_PAYLOAD = 4'd3;
	localparam logic [3:0] ST_CHECK   = 4'd4;
	localparam logic [3:0] ST_READ    = 4'd5;
	localparam logic [3:0] ST_GATHER  = 4'd6;
	localparam logic [3:0] ST_LOAD    = 4'd7;
	localparam logic [3:0] ST_WAIT    = 4'd8;

	logic [3:0]                        state_q;
	logic [7:0]                        len_q;
	logic [7:0]                        seen_q;
	logic [msfr_pkg::GRP_W-1:0]        grp_q;
	logic [msfr_pkg::LANE_W-1:0]       lane_q;
	logic                              rd_vld_s1;
	logic                              acc;
	logic [7:0]                        seen_nx;
	logic [msfr_pkg::GRP_W-1:0]        grp_cnt;
	logic                              last_grp;

	assign in_ready  = (state_q == ST_IDLE) || (state_q == ST_GOT_AA)
		|| (state_q == ST_LENGTH) || (state_q == ST_PAYLOAD) || (state_q == ST_CHECK);
	assign out_valid = (state_q == ST_WAIT);
	assign acc       = in_valid && in_ready;
	assign seen_nx   = seen_q + 8'd1;
	assign grp_cnt   = len_q[7:3];
	assign last_grp  = (grp_q == grp_cnt - 5'd1);

	always_comb begin
		cmd         = '0;
		cmd.ram_we  = acc && (state_q == ST_PAYLOAD);
		cmd.sum_add = acc && (state_q == ST_PAYLOAD);
		cmd.sum_clr = acc && (state_q == ST_LENGTH);
		cmd.ram_re  = (state_q == ST_READ);
		cmd.addr    = (state_q == ST_READ) ? {grp_q, lane_q} : seen_q;
		cmd.shift   = rd_vld_s1;
		cmd.load    = (state_q == ST_LOAD);
		cmd.last    = last_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			seen_q    <= '0;
			grp_q     <= '0;
			lane_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (acc && rx_byte == msfr_pkg::HDR_FIRST) state_q <= ST_GOT_AA;
				end
				ST_GOT_AA: begin
					if (acc) begin
						if (rx_byte == msfr_pkg::HDR_SECOND) state_q <= ST_LENGTH;
						else if (rx_byte != msfr_pkg::HDR_FIRST) state_q <= ST_IDLE;
					end
				end
				ST_LENGTH: begin
					if (acc) begin
						len_q   <= rx_byte;
						seen_q  <= '0;
						state_q <= (rx_byte == 8'd0) ? ST_CHECK : ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					if (acc) begin
						seen_q <= seen_nx;
						if (seen_nx >= len_q) state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (acc) begin
						grp_q  <= '0;
						lane_q <= '0;
						// a good frame with fewer than eight bytes has no records
						if (status.sum_ok && grp_cnt != '0) state_q <= ST_READ;
						else state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					lane_q <= lane_q + 3'd1;
					if (lane_q == 3'd7) state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_ready) begin
						if (last_grp) begin
							state_q <= ST_IDLE;
						end else begin
							grp_q   <= grp_q + 5'd1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/motor_status_frame_receiver.sv
// a byte beat is taken every cycle that one is offered while hunting or filling a frame;
// after a good checksum beat each record is built by 8 reads of the single-port payload
// ram, then gather and load, and each further record starts once the previous record
// beat is taken; no byte is taken while records drain
// reset: async active low, hunt idle, homed flag clear, registers at their defaults
module motor_status_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	msfr_byte_if.sink                      rx,
	msfr_rec_if.source                     rec,
	input  logic                           cfg_we,
	input  logic [msfr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [msfr_pkg::CFG_W-1:0]     cfg_data
);

	msfr_pkg::cmd_t    cmd;
	msfr_pkg::status_t status;
	msfr_pkg::rec_t    rec_d;

	msfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.rx_byte   (rx.rx_byte),
		.out_valid (rec.valid),
		.out_ready (rec.ready),
		.status    (status),
		.cmd       (cmd)
	);

	msfr_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.rx_byte  (rx.rx_byte),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rec      (rec_d)
	);

	assign rec.angle          = rec_d.angle;
	assign rec.speed          = rec_d.speed;
	assign rec.current        = rec_d.current;
	assign rec.temperature    = rec_d.temperature;
	assign rec.motor_number   = rec_d.motor_number;
	assign rec.homing_trigger = rec_d.homing_trigger;
	assign rec.last           = rec_d.last;

endmodule

### verif/motor_status_frame_receiver_tb.sv
// testbench for the motor status frame receiver: random byte stream, predicted records
module motor_status_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH  = 256;
	localparam int GROUP_BYTES  = 8;
	localparam int MAX_GROUPS   = 31;
	localparam int MAX_WAIT     = 12;
	localparam int HOLD_CYCLES  = 700;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [msfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef logic [7:0] octet_t;
	typedef enum logic [2:0] {
		HUNT_IDLE, HUNT_GOT_AA, HUNT_LENGTH, HUNT_PAYLOAD, HUNT_CHECK
	} hunt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [msfr_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [msfr_pkg::CFG_W-1:0] cfg_data;

	msfr_byte_if bytes_in();
	msfr_rec_if recs_out();

	motor_status_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (bytes_in),
		.rec      (recs_out),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// register copies
	logic homing_on;
	logic [7:0] watched_id;
	logic [15:0] trip_level;

	// decoder state
	hunt_t hunt = HUNT_IDLE;
	logic [7:0] frame_len = '0;
	logic [7:0] seen = '0;
	logic [7:0] sum = '0;
	logic [7:0] payload_mem [STORE_DEPTH];
	logic homed = 1'b0;

	msfr_pkg::rec_t pending_records[$];
	octet_t byte_q[$];
	octet_t frame_body[$];
	int bytes_queued;
	int bytes_taken;
	int errors;
	int cycle_count;
	int src_wait;
	int sink_wait;
	bit hold_armed;
	bit hold_done;
	bit calm;
	logic rx_fire;
	logic rec_fire;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic emit_records();
		int count;
		int g;
		int base;
		msfr_pkg::rec_t r;
		logic [16:0] mag;
		count = frame_len / GROUP_BYTES;
		for (g = 0; g < count; g++) begin
			base = g * GROUP_BYTES;
			r.angle = {payload_mem[base], payload_mem[base + 1]};
			r.speed = {payload_mem[base + 2], payload_mem[base + 3]};
			r.current = {payload_mem[base + 4], payload_mem[base + 5]};
			r.temperature = payload_mem[base + 6];
			r.motor_number = payload_mem[base + 7];
			// magnitude on 17 bits so -32768 gives 32768
			mag = r.current[15] ? 17'h10000 - {1'b0, r.current} : {1'b0, r.current};
			r.homing_trigger = 1'b0;
			if (homing_on && r.motor_number == watched_id && !homed &&
					mag >= {1'b0, trip_level}) begin
				homed = 1'b1;
				r.homing_trigger = 1'b1;
			end
			r.last = (g == count - 1);
			pending_records.push_back(r);
		end
	endtask

	task automatic decode_byte(input octet_t b);
		case (hunt)
			HUNT_GOT_AA: begin
				if (b == msfr_pkg::HDR_SECOND)
					hunt = HUNT_LENGTH;
				else if (b != msfr_pkg::HDR_FIRST)
					hunt = HUNT_IDLE;
			end
			HUNT_LENGTH: begin
				frame_len = b;
				seen = '0;
				sum = '0;
				hunt = (b == 8'd0) ? HUNT_CHECK : HUNT_PAYLOAD;
			end
			HUNT_PAYLOAD: begin
				payload_mem[seen] = b;
				sum = sum + b;
				seen = seen + 8'd1;
				if (seen >= frame_len)
					hunt = HUNT_CHECK;
			end
			HUNT_CHECK: begin
				if (b == sum)
					emit_records();
				hunt = HUNT_IDLE;
			end
			default: begin
				hunt = (b == msfr_pkg::HDR_FIRST) ? HUNT_GOT_AA : HUNT_IDLE;
			end
		endcase
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic check_record();
		msfr_pkg::rec_t want;
		if (pending_records.size() == 0) begin
			$display("%0t: record with none expected, angle %0h motor %0h", $time,
				recs_out.angle, recs_out.motor_number);
			errors++;
		end else begin
			want = pending_records.pop_front();
			check_field("angle", want.angle, recs_out.angle);
			check_field("speed", want.speed, recs_out.speed);
			check_field("current", want.current, recs_out.current);
			check_field("temperature", want.temperature, recs_out.temperature);
			check_field("motor_number", want.motor_number, recs_out.motor_number);
			check_field("homing_trigger", want.homing_trigger, recs_out.homing_trigger);
			check_field("last", want.last, recs_out.last);
		end
	endtask

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			bytes_in.valid <= 1'b0;
			bytes_in.rx_byte <= '0;
			src_wait = 0;
		end else if (!bytes_in.valid || rx_fire) begin
			if (rx_fire)
				src_wait = draw_wait();
			if (src_wait > 0) begin
				src_wait--;
				bytes_in.valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				bytes_in.valid <= 1'b1;
				bytes_in.rx_byte <= byte_q.pop_front();
			end else begin
				bytes_in.valid <= 1'b0;
			end
		end
	end

	// record sink, with one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			recs_out.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (rec_fire)
				sink_wait = draw_wait();
			if (hold_armed && !hold_done) begin
				sink_wait = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				recs_out.ready <= 1'b0;
			end else begin
				recs_out.ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_fire <= 1'b0;
			rec_fire <= 1'b0;
		end else begin
			rx_fire <= bytes_in.valid && bytes_in.ready;
			rec_fire <= recs_out.valid && recs_out.ready;
			if (recs_out.valid && recs_out.ready)
				check_record();
			if (bytes_in.valid && bytes_in.ready) begin
				decode_byte(bytes_in.rx_byte);
				bytes_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("motor_status_frame_receiver_tb: errors");
			$finish;
		end
	end

	task automatic push_byte(input octet_t b);
		byte_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic add_record(input logic [15:0] angle, input logic [15:0] speed,
			input logic [15:0] current, input octet_t temp, input octet_t id);
		frame_body.push_back(angle[15:8]);
		frame_body.push_back(angle[7:0]);
		frame_body.push_back(speed[15:8]);
		frame_body.push_back(speed[7:0]);
		frame_body.push_back(current[15:8]);
		frame_body.push_back(current[7:0]);
		frame_body.push_back(temp);
		frame_body.push_back(id);
	endtask

	task automatic random_record();
		logic [15:0] cur;
		octet_t id;
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0: cur = 16'h8000;
			1: cur = 16'h7FFF;
			2: cur = 16'h0000;
			default: cur = 16'($urandom);
		endcase
		id = $urandom_range(0, 1) ? watched_id : octet_t'($urandom);
		add_record(16'($urandom), 16'($urandom), cur, octet_t'($urandom), id);
	endtask

	// header, length, body, then checksum (corrupted on request)
	task automatic send_frame(input bit spoil);
		octet_t total;
		total = '0;
		foreach (frame_body[i])
			total = total + frame_body[i];
		push_byte(msfr_pkg::HDR_FIRST);
		push_byte(msfr_pkg::HDR_SECOND);
		push_byte(8'(frame_body.size()));
		foreach (frame_body[i])
			push_byte(frame_body[i]);
		push_byte(spoil ? total ^ octet_t'($urandom_range(1, 255)) : total);
		frame_body.delete();
	endtask

	task automatic random_traffic(input int budget);
		int used;
		int k;
		int nrec;
		int tail;
		int i;
		used = 0;
		while (used < budget) begin
			calm = ($urandom_range(0, 5) == 0);
			k = $urandom_range(0, 99);
			if (k < 80) begin
				nrec = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 8)
					: $urandom_range(1, 4);
				tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
				for (i = 0; i < nrec; i++)
					random_record();
				for (i = 0; i < tail; i++)
					frame_body.push_back(octet_t'($urandom));
				used += frame_body.size() + 4;
				send_frame(k >= 70);
			end else if (k < 90) begin
				// zero length or a short frame with no whole group
				tail = (k < 85) ? 0 : $urandom_range(1, 7);
				for (i = 0; i < tail; i++)
					frame_body.push_back(octet_t'($urandom));
				used += tail + 4;
				send_frame($urandom_range(0, 3) == 0);
			end else begin
				// line noise, often a stray first header byte
				tail = $urandom_range(1, 6);
				for (i = 0; i < tail; i++)
					push_byte($urandom_range(0, 2) == 0 ? msfr_pkg::HDR_FIRST
						: octet_t'($urandom));
				used += tail;
			end
		end
		calm = 1'b0;
	endtask

	task automatic write_reg(input logic [msfr_pkg::CFG_IDX_W-1:0] idx,
			input logic [msfr_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			msfr_pkg::CFG_HOMING_ENABLE:   homing_on = value[0];
			msfr_pkg::CFG_HOMING_MOTOR_ID: watched_id = value[7:0];
			msfr_pkg::CFG_CURRENT_THRESH:  trip_level = value;
			default: ;
		endcase
	endtask

	task automatic settle();
		while (bytes_taken != bytes_queued || pending_records.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		homing_on = 1'b0;
		watched_id = 8'd1;
		trip_level = 16'd32767;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// repeated first header byte, zero length frame
		push_byte(msfr_pkg::HDR_FIRST); push_byte(msfr_pkg::HDR_FIRST);
		push_byte(msfr_pkg::HDR_SECOND);
		push_byte(8'h00); push_byte(8'h00);
		// broken header, then a frame with only a partial group
		push_byte(8'h5A); push_byte(msfr_pkg::HDR_FIRST); push_byte(8'h31);
		frame_body = '{8'h01, 8'h02, 8'h03};
		send_frame(1'b0);
		// field extremes, homing still off
		add_record(16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 8'h01);
		add_record(16'h0000, 16'h8000, 16'h7FFF, 8'h00, 8'h00);
		send_frame(1'b0);
		frame_body = '{8'h7F};
		send_frame(1'b1);
		settle();

		// threshold above any magnitude: never trips
		write_reg(msfr_pkg::CFG_HOMING_ENABLE, 16'd1);
		write_reg(msfr_pkg::CFG_HOMING_MOTOR_ID, 16'd1);
		write_reg(msfr_pkg::CFG_CURRENT_THRESH, 16'hFFFF);
		add_record(16'h1234, 16'h0000, 16'h8000, 8'h20, 8'h01);
		send_frame(1'b0);
		random_traffic(10);
		settle();

		// -32768 reaches a threshold of 32768, only the first record trips
		write_reg(msfr_pkg::CFG_CURRENT_THRESH, 16'h8000);
		add_record(16'h0102, 16'h0304, 16'h8000, 8'h30, 8'h01);
		add_record(16'h0506, 16'h0708, 16'h8000, 8'h31, 8'h01);
		add_record(16'h090A, 16'h0B0C, 16'h7FFF, 8'h32, 8'h01);
		send_frame(1'b0);
		settle();

		// new watched id and zero threshold after homing: no further trip
		write_reg(msfr_pkg::CFG_HOMING_MOTOR_ID, 16'd0);
		write_reg(msfr_pkg::CFG_CURRENT_THRESH, 16'd0);
		random_traffic(15);
		settle();

		write_reg(msfr_pkg::CFG_HOMING_ENABLE, 16'd0);
		write_reg(msfr_pkg::CFG_HOMING_MOTOR_ID, 16'd255);
		write_reg(msfr_pkg::CFG_CURRENT_THRESH, 16'($urandom));
		write_reg(CFG_SPARE, 16'($urandom));
		random_traffic(15);
		settle();

		// sink holds off while a full frame and more arrive back to back
		write_reg(msfr_pkg::CFG_HOMING_ENABLE, 16'd1);
		calm = 1'b1;
		hold_armed = 1'b1;
		repeat (MAX_GROUPS) random_record();
		repeat (7) frame_body.push_back(octet_t'($urandom));
		send_frame(1'b0);
		repeat (2) random_record();
		send_frame(1'b0);
		random_record();
		send_frame(1'b0);
		settle();
		calm = 1'b0;

		write_reg(msfr_pkg::CFG_CURRENT_THRESH, 16'($urandom_range(0, 32768)));
		random_traffic(20);
		settle();

		if (errors == 0 && pending_records.size() == 0)
			$display("motor_status_frame_receiver_tb: clean");
		else
			$display("motor_status_frame_receiver_tb: errors");
		$finish;
	end

endmodule
